@@ rtl/dsfr_pkg.sv @@
`default_nettype none

package dsfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_DLE  = 8'h10;
    localparam logic [7:0] CH_NACK = 8'h15;

    localparam logic [7:0] CODE_PARITY = 8'h01;
    localparam logic [7:0] CODE_NUMBER = 8'h02;
    localparam logic [7:0] CODE_LENGTH = 8'h03;

    localparam logic [7:0] NUM_WRAP_FROM = 8'hFF;
    localparam logic [7:0] NUM_WRAP_TO   = 8'h7F;

    typedef enum logic [0:0] {
        OP_RX_BYTE = 1'b0,
        OP_READ    = 1'b1
    } t_operation;

    typedef enum logic [2:0] {
        ST_BYTE_TAKEN  = 3'd0,
        ST_NACK_SEEN   = 3'd1,
        ST_ERROR       = 3'd2,
        ST_FRAME_READY = 3'd3,
        ST_READ_DATA   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_PARITY  = 3'd1,
        CAUSE_LENGTH  = 3'd2,
        CAUSE_NUMBER  = 3'd3,
        CAUSE_PARTNER = 3'd4
    } t_cause;

    typedef struct packed {
        t_operation operation;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        t_cause     error_cause;
        logic [7:0] partner_code;
        logic [1:0] tx_count;
        logic [7:0] tx_first;
        logic [7:0] tx_second;
        logic       resend_request;
        logic [8:0] payload_length;
        logic [7:0] read_data;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/dle_stuffed_frame_receiver_top.sv @@
`default_nettype none

// Receives DLE-stuffed serial bytes one beat at a time, strips the escapes and
// stores the data bytes in an on-chip frame buffer, answering each beat with
// exactly one result beat that carries the reply bytes, status and fill. A new
// beat is accepted every cycle unless a stalled result blocks it, and its
// result shows in the cycle after acceptance. The buffer is a two-read-port
// memory with a registered read: a payload read returns its byte through the
// first port; a good frame reloads the two newest bytes it keeps through both
// ports, ready for the next beat. The buffer needs no clearing after reset.
module dle_stuffed_frame_receiver_top #(
    parameter int BUFFER_DEPTH = dsfr_pkg::BUFFER_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  dsfr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output dsfr_pkg::t_out_item o_out_data
);
    import dsfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (FW > 8) ? FW : 8;
    localparam int PW = (FW > 9) ? FW : 9;

    logic [7:0] r_mem [BUFFER_DEPTH];

    logic [FW-1:0] r_fill, n_fill;
    logic          r_esc, n_esc;
    logic          r_nack, n_nack;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_last_num, n_last_num;
    logic [7:0]    r_last, n_last;
    logic [7:0]    r_second, n_second;
    logic          r_fetch, n_fetch;
    logic [7:0]    r_rd_a, r_rd_b;
    logic          r_out_valid;
    logic          r_out_rd;
    t_out_item     r_out;

    logic          accept;
    logic [7:0]    eff_last, eff_second, c;
    logic          wr_en, rd_a_en, rd_b_en, do_store, do_clear, in_range;
    logic [AW-1:0] wr_addr, addr_a, addr_b;
    logic [PW-1:0] fill_ext;
    t_out_item     res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign eff_last   = r_fetch ? r_rd_a : r_last;
    assign eff_second = r_fetch ? r_rd_b : r_second;
    assign c          = i_in_data.rx_byte;
    assign in_range   = (CW'(i_in_data.read_index) < CW'(r_fill))
                        && (CW'(i_in_data.read_index) < CW'(BUFFER_DEPTH));

    always_comb begin
        n_fill     = r_fill;
        n_esc      = r_esc;
        n_nack     = r_nack;
        n_xor      = r_xor;
        n_last_num = r_last_num;
        n_last     = eff_last;
        n_second   = eff_second;
        n_fetch    = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = AW'(r_fill);
        rd_a_en    = 1'b0;
        rd_b_en    = 1'b0;
        addr_a     = AW'(i_in_data.read_index);
        addr_b     = AW'(r_fill - FW'(4));
        do_store   = 1'b0;
        do_clear   = 1'b0;
        res        = '0;

        if (accept) begin
            if (i_in_data.operation == OP_READ) begin
                res.status = ST_READ_DATA;
                rd_a_en    = 1'b1;
            end else if (r_esc) begin
                n_esc    = 1'b0;
                do_store = 1'b1;
            end else if (r_nack) begin
                n_nack   = 1'b0;
                do_clear = 1'b1;
                if (c == CODE_PARITY) begin
                    res.resend_request = 1'b1;
                end else begin
                    res.status       = ST_ERROR;
                    res.error_cause  = CAUSE_PARTNER;
                    res.partner_code = c;
                end
            end else if (c == CH_NACK) begin
                n_nack     = 1'b1;
                res.status = ST_NACK_SEEN;
            end else if (c == CH_ACK || c == CH_SOH) begin
                do_clear = 1'b1;
            end else if (c == CH_DLE) begin
                n_esc = 1'b1;
            end else if (c == CH_EOT) begin
                res.tx_first = CH_NACK;
                res.tx_count = 2'd2;
                res.status   = ST_ERROR;
                if (r_xor != 8'h00) begin
                    res.error_cause = CAUSE_PARITY;
                    res.tx_second   = CODE_PARITY;
                    do_clear        = 1'b1;
                end else if (r_fill < FW'(4)) begin
                    res.error_cause = CAUSE_LENGTH;
                    res.tx_second   = CODE_LENGTH;
                    do_clear        = 1'b1;
                end else if (r_last_num != 8'h00 && eff_second <= r_last_num) begin
                    res.error_cause = CAUSE_NUMBER;
                    res.tx_second   = CODE_NUMBER;
                    do_clear        = 1'b1;
                end else begin
                    res.status   = ST_FRAME_READY;
                    res.tx_count = 2'd1;
                    res.tx_first = CH_ACK;
                    n_last_num   = (eff_second == NUM_WRAP_FROM) ? NUM_WRAP_TO : eff_second;
                    n_xor        = r_xor ^ eff_last ^ eff_second;
                    n_fill       = r_fill - FW'(2);
                    addr_a       = AW'(r_fill - FW'(3));
                    rd_a_en      = 1'b1;
                    rd_b_en      = 1'b1;
                    n_fetch      = 1'b1;
                end
            end else begin
                do_store = 1'b1;
            end

            if (do_store) begin
                if (r_fill < FW'(BUFFER_DEPTH)) begin
                    wr_en    = 1'b1;
                    n_fill   = r_fill + FW'(1);
                    n_xor    = r_xor ^ c;
                    n_second = eff_last;
                    n_last   = c;
                end else begin
                    res.status      = ST_ERROR;
                    res.error_cause = CAUSE_LENGTH;
                    res.tx_count    = 2'd2;
                    res.tx_first    = CH_NACK;
                    res.tx_second   = CODE_LENGTH;
                    do_clear        = 1'b1;
                end
            end

            if (do_clear) begin
                n_fill   = '0;
                n_xor    = 8'h00;
                n_last   = 8'h00;
                n_second = 8'h00;
            end
        end

        fill_ext           = PW'(n_fill);
        res.payload_length = fill_ext[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_a_en) begin
            r_rd_a <= r_mem[addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_b_en) begin
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_esc       <= 1'b0;
            r_nack      <= 1'b0;
            r_xor       <= 8'h00;
            r_last_num  <= 8'h00;
            r_last      <= 8'h00;
            r_second    <= 8'h00;
            r_fetch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_esc      <= n_esc;
            r_nack     <= n_nack;
            r_xor      <= n_xor;
            r_last_num <= n_last_num;
            r_last     <= n_last;
            r_second   <= n_second;
            r_fetch    <= n_fetch;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out    <= res;
            r_out_rd <= (i_in_data.operation == OP_READ) && in_range;
        end
    end

    always_comb begin
        o_out_data           = r_out;
        o_out_data.read_data = r_out_rd ? r_rd_a : 8'h00;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/dsfr_checker.sv @@
`default_nettype none

module dsfr_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input dsfr_pkg::t_out_item o_out_data
);
    import dsfr_pkg::*;

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    a_read_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_READ_DATA
        |-> o_out_data.tx_count == 2'd0 && o_out_data.error_cause == CAUSE_NONE)
        else $error("read beat carries a reply");

    a_frame_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FRAME_READY
        |-> o_out_data.tx_count == 2'd1 && o_out_data.tx_first == CH_ACK)
        else $error("good frame not acknowledged");

    a_check_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_cause == CAUSE_PARITY
        || o_out_data.error_cause == CAUSE_LENGTH
        || o_out_data.error_cause == CAUSE_NUMBER)
        |-> o_out_data.tx_count == 2'd2 && o_out_data.tx_first == CH_NACK
        && o_out_data.payload_length == 9'd0)
        else $error("failed check without NACK or with data left in the buffer");

endmodule

bind dle_stuffed_frame_receiver_top dsfr_checker u_dsfr_checker (.*);

`default_nettype wire
